@@ src/priority_inheritance_mutex_macros.svh @@
// Assertion macros used by the checker file of the mutex block.
// Each macro takes a label, the clock, the active-low reset, a condition
// and the expectation that the condition implies.
`ifndef PRIORITY_INHERITANCE_MUTEX_MACROS_SVH
`define PRIORITY_INHERITANCE_MUTEX_MACROS_SVH

// The expectation must hold in the same cycle as the condition.
`define PIM_ASSERT_NOW(label, clk, rst_n, cond, expect_now) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expect_now)) \
		else $error("mutex check failed in the same cycle");

// The expectation must hold in the cycle after the condition.
`define PIM_ASSERT_NEXT(label, clk, rst_n, cond, expect_next) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_next)) \
		else $error("mutex check failed in the following cycle");

`endif

@@ src/pim_pkg.sv @@
// ----------------------------------------------------------------------------
// pim_pkg
// Types, codes and sizes shared by the priority-inheritance mutex modules.
// ----------------------------------------------------------------------------
package pim_pkg;

	localparam int ID_W           = 8;
	localparam int PRIO_W         = 8;
	localparam int RCOUNT_W       = 8;
	localparam int STATUS_W       = 3;
	localparam int COUNT_OUT_W    = 4;
	localparam int WAIT_SLOTS_DEF = 8;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [1:0] OP_LOCK    = 2'd0;
	localparam logic [1:0] OP_TRYLOCK = 2'd1;
	localparam logic [1:0] OP_UNLOCK  = 2'd2;

	localparam logic [RCOUNT_W-1:0] RCOUNT_MAX = '1;

	typedef enum logic [1:0] {
		K_LOCK,
		K_TRYLOCK,
		K_UNLOCK,
		K_INVALID
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ACQUIRED,
		ST_REENTERED,
		ST_QUEUED,
		ST_BUSY,
		ST_FULL,
		ST_NOT_OWNER,
		ST_DECREMENTED,
		ST_RELEASED
	} status_t;

	typedef struct packed {
		kind_t             kind;
		logic [ID_W-1:0]   task_id;
		logic [PRIO_W-1:0] task_priority;
	} cmd_t;

	typedef struct packed {
		logic [ID_W-1:0]   task_id;
		logic [PRIO_W-1:0] task_priority;
	} waiter_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_PICK,
		B_EMIT
	} bstate_t;

endpackage

@@ src/pim_if.sv @@
// ----------------------------------------------------------------------------
// pim_req_if / pim_rsp_if
// Valid/ready channels for mutex requests and their results.
// ----------------------------------------------------------------------------
interface pim_req_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                op;
	logic [pim_pkg::ID_W-1:0]   task_id;
	logic [pim_pkg::PRIO_W-1:0] task_priority;

	modport source (output valid, output op, output task_id, output task_priority,
		input ready);
	modport sink (input valid, input op, input task_id, input task_priority,
		output ready);
endinterface

interface pim_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [pim_pkg::STATUS_W-1:0]    status;
	logic                           woken_valid;
	logic [pim_pkg::ID_W-1:0]        woken_task;
	logic                           owner_valid;
	logic [pim_pkg::ID_W-1:0]        owner_task;
	logic [pim_pkg::PRIO_W-1:0]      owner_priority;
	logic [pim_pkg::COUNT_OUT_W-1:0] waiter_count;

	modport source (output valid, output status, output woken_valid, output woken_task,
		output owner_valid, output owner_task, output owner_priority, output waiter_count,
		input ready);
	modport sink (input valid, input status, input woken_valid, input woken_task,
		input owner_valid, input owner_task, input owner_priority, input waiter_count,
		output ready);
endinterface

@@ src/pim_front.sv @@
// ----------------------------------------------------------------------------
// pim_front
// Accepts request items and classifies their operation codes.
// ----------------------------------------------------------------------------
module pim_front (
	pim_req_if.sink       req,
	output logic          push_valid,
	input  logic          push_ready,
	output pim_pkg::cmd_t push_data
);
	import pim_pkg::*;

	kind_t kind;

	always_comb begin
		case (req.op)
			OP_LOCK:    kind = K_LOCK;
			OP_TRYLOCK: kind = K_TRYLOCK;
			OP_UNLOCK:  kind = K_UNLOCK;
			default:    kind = K_INVALID;
		endcase
	end

	assign push_valid              = req.valid;
	assign req.ready               = push_ready;
	assign push_data.kind          = kind;
	assign push_data.task_id       = req.task_id;
	assign push_data.task_priority = req.task_priority;

endmodule

@@ src/pim_queue.sv @@
// ----------------------------------------------------------------------------
// pim_queue
// Short FIFO of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module pim_queue #(
	parameter int DEPTH = pim_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  pim_pkg::cmd_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output pim_pkg::cmd_t pop_data
);
	import pim_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ src/pim_back.sv @@
// ----------------------------------------------------------------------------
// pim_back
// Carries out mutex commands: ownership, recursion, boosting and the waiter
// table, with a slot-by-slot scan for the waiter to wake on final unlock.
// ----------------------------------------------------------------------------
module pim_back #(
	parameter int WAIT_SLOTS = pim_pkg::WAIT_SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  pim_pkg::cmd_t cmd,
	pim_rsp_if.source     rsp
);
	import pim_pkg::*;

	localparam int CNT_W  = $clog2(WAIT_SLOTS + 1);
	localparam int ADDR_W = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WAIT_SLOTS);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	bstate_t             state_q;
	bstate_t             state_d;

	// Owner state. The base priority is not kept: the final unlock clears
	// the owner fields, so a restored base priority never becomes visible.
	logic                held_q;
	logic [ID_W-1:0]     owner_id_q;
	logic [PRIO_W-1:0]   eff_q;
	logic [RCOUNT_W-1:0] rcount_q;
	logic [CNT_W-1:0]    used_q;

	logic [CNT_W-1:0]    idx_q;
	logic [ADDR_W-1:0]   best_q;
	waiter_t             best_q_w;
	status_t             status_q;
	logic                woke_q;
	logic [ID_W-1:0]     woken_q;

	waiter_t             mem [WAIT_SLOTS];
	waiter_t             rd_data_q;
	logic [ADDR_W-1:0]   rd_addr;
	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	waiter_t             wr_data;

	logic                out_valid_q;
	status_t             out_status_q;
	logic                out_woke_q;
	logic [ID_W-1:0]     out_woken_q;
	logic                out_held_q;
	logic [ID_W-1:0]     out_owner_q;
	logic [PRIO_W-1:0]   out_prio_q;
	logic [COUNT_OUT_W-1:0] out_count_q;

	logic                take_cmd;
	logic                is_owner;
	logic                table_full;
	logic                final_unlock;
	logic                start_scan;
	logic                enqueue;
	logic                scan_take;
	logic                load_out;

	assign take_cmd     = (state_q == B_IDLE) && cmd_valid;
	assign is_owner     = held_q && (owner_id_q == cmd.task_id);
	assign table_full   = (used_q >= CNT_FULL);
	assign final_unlock = (cmd.kind == K_UNLOCK) && is_owner && (rcount_q <= 8'd1);
	assign start_scan   = take_cmd && final_unlock && (used_q != '0);
	assign enqueue      = take_cmd && (cmd.kind == K_LOCK) && held_q && !is_owner && !table_full;
	// The first slot always seeds the search; later slots replace it only
	// when strictly higher, which keeps the lowest slot on ties.
	assign scan_take    = (idx_q == CNT_ONE) || (rd_data_q.task_priority > best_q_w.task_priority);
	assign load_out     = (state_q == B_EMIT) && (!out_valid_q || rsp.ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					state_d = start_scan ? B_SCAN : B_EMIT;
				end
			end
			B_SCAN: begin
				if (idx_q == used_q) begin
					state_d = B_PICK;
				end
			end
			B_PICK: state_d = B_EMIT;
			B_EMIT: begin
				if (load_out) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = ADDR_W'(used_q);
		wr_data   = '{task_id: cmd.task_id, task_priority: cmd.task_priority};
		case (state_q)
			B_IDLE: begin
				cmd_ready = 1'b1;
				wr_en     = enqueue;
			end
			B_SCAN: begin
				// Once every slot is read, fetch the last one to fill the hole.
				rd_addr = (idx_q < used_q) ? ADDR_W'(idx_q) : ADDR_W'(used_q - CNT_ONE);
			end
			B_PICK: begin
				wr_en   = 1'b1;
				wr_addr = best_q;
				wr_data = rd_data_q;
			end
			B_EMIT: begin
				cmd_ready = 1'b0;
			end
			default: cmd_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			held_q     <= 1'b0;
			owner_id_q <= '0;
			eff_q      <= '0;
			rcount_q   <= '0;
			used_q     <= '0;
		end else begin
			state_q <= state_d;
			if (take_cmd) begin
				case (cmd.kind)
					K_LOCK, K_TRYLOCK: begin
						if (!held_q) begin
							held_q     <= 1'b1;
							owner_id_q <= cmd.task_id;
							eff_q      <= cmd.task_priority;
							rcount_q   <= 8'd1;
						end else if (is_owner) begin
							if (rcount_q != RCOUNT_MAX) begin
								rcount_q <= rcount_q + 1'b1;
							end
						end else if (cmd.kind == K_LOCK) begin
							if (cmd.task_priority > eff_q) begin
								eff_q <= cmd.task_priority;
							end
							if (!table_full) begin
								used_q <= used_q + 1'b1;
							end
						end
					end
					K_UNLOCK: begin
						if (is_owner) begin
							if (final_unlock) begin
								held_q     <= 1'b0;
								owner_id_q <= '0;
								eff_q      <= '0;
								rcount_q   <= '0;
							end else begin
								rcount_q <= rcount_q - 1'b1;
							end
						end
					end
					default: begin
						held_q <= held_q;
					end
				endcase
			end else if (state_q == B_PICK) begin
				used_q <= used_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_cmd) begin
			woke_q  <= 1'b0;
			woken_q <= '0;
			idx_q   <= CNT_ONE;
			case (cmd.kind)
				K_LOCK, K_TRYLOCK: begin
					if (!held_q) begin
						status_q <= ST_ACQUIRED;
					end else if (is_owner) begin
						status_q <= (rcount_q == RCOUNT_MAX) ? ST_BUSY : ST_REENTERED;
					end else if (cmd.kind == K_TRYLOCK) begin
						status_q <= ST_BUSY;
					end else begin
						status_q <= table_full ? ST_FULL : ST_QUEUED;
					end
				end
				K_UNLOCK: begin
					if (!is_owner) begin
						status_q <= ST_NOT_OWNER;
					end else if (final_unlock) begin
						status_q <= ST_RELEASED;
					end else begin
						status_q <= ST_DECREMENTED;
					end
				end
				default: status_q <= ST_BUSY;
			endcase
		end
		if (state_q == B_SCAN) begin
			if (scan_take) begin
				best_q   <= ADDR_W'(idx_q - CNT_ONE);
				best_q_w <= rd_data_q;
			end
			if (idx_q < used_q) begin
				idx_q <= idx_q + 1'b1;
			end
		end
		if (state_q == B_PICK) begin
			woke_q  <= 1'b1;
			woken_q <= best_q_w.task_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= status_q;
			out_woke_q   <= woke_q;
			out_woken_q  <= woken_q;
			out_held_q   <= held_q;
			out_owner_q  <= owner_id_q;
			out_prio_q   <= eff_q;
			out_count_q  <= COUNT_OUT_W'(used_q);
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.woken_valid    = out_woke_q;
	assign rsp.woken_task     = out_woken_q;
	assign rsp.owner_valid    = out_held_q;
	assign rsp.owner_task     = out_owner_q;
	assign rsp.owner_priority = out_prio_q;
	assign rsp.waiter_count   = out_count_q;

endmodule

@@ src/priority_inheritance_mutex.sv @@
// ----------------------------------------------------------------------------
// priority_inheritance_mutex
// Recursive hardware mutex with priority inheritance and a waiter table.
//
//   channel  dir  fields
//   req      in   op, task_id, task_priority
//   rsp      out  status, woken_valid, woken_task, owner_valid, owner_task,
//                 owner_priority, waiter_count
//
// A request passes through the two-entry command queue and the back end's
// status register to the result register. A final unlock with queued waiters
// also scans the waiter memory, which is read one slot a cycle.
// Reset clears ownership and the waiter count; no clearing pass is needed.
// A stalled result holds the back end, while the queue keeps taking items until it is full.
// ----------------------------------------------------------------------------
module priority_inheritance_mutex #(
	parameter int WAIT_SLOTS = pim_pkg::WAIT_SLOTS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	pim_req_if.sink   req,
	pim_rsp_if.source rsp
);
	import pim_pkg::*;

	logic push_valid;
	logic push_ready;
	cmd_t push_data;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_data;

	pim_front u_front (
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	pim_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	pim_back #(
		.WAIT_SLOTS (WAIT_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd_ready (pop_ready),
		.cmd       (pop_data),
		.rsp       (rsp)
	);

endmodule

@@ src/pim_checker.sv @@
// ----------------------------------------------------------------------------
// pim_checker
// Port-level checks of the mutex results, bound to the top level.
// ----------------------------------------------------------------------------
`include "priority_inheritance_mutex_macros.svh"

module pim_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic [pim_pkg::STATUS_W-1:0]      status,
	input logic                              woken_valid,
	input logic [pim_pkg::ID_W-1:0]          woken_task,
	input logic                              owner_valid,
	input logic [pim_pkg::ID_W-1:0]          owner_task,
	input logic [pim_pkg::PRIO_W-1:0]        owner_priority,
	input logic [pim_pkg::COUNT_OUT_W-1:0]   waiter_count
);
	import pim_pkg::*;

	// A result that is not taken stays on the port unchanged.
	`PIM_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(woken_task) && $stable(waiter_count))

	// Only a final unlock can wake a waiter, and it leaves the mutex free.
	`PIM_ASSERT_NOW(a_wake_on_release, clk, arst_n, rsp_valid && woken_valid, status == ST_RELEASED && !owner_valid)

	// A free mutex reports no owner and no priority.
	`PIM_ASSERT_NOW(a_free_fields, clk, arst_n, rsp_valid && !owner_valid, owner_task == '0 && owner_priority == '0)

	// These outcomes all leave the mutex held.
	`PIM_ASSERT_NOW(a_held_after, clk, arst_n, rsp_valid && (status == ST_ACQUIRED || status == ST_REENTERED || status == ST_QUEUED || status == ST_DECREMENTED), owner_valid)

endmodule

bind priority_inheritance_mutex pim_checker u_pim_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.status         (rsp.status),
	.woken_valid    (rsp.woken_valid),
	.woken_task     (rsp.woken_task),
	.owner_valid    (rsp.owner_valid),
	.owner_task     (rsp.owner_task),
	.owner_priority (rsp.owner_priority),
	.waiter_count   (rsp.waiter_count)
);
